// ===== src/jsu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helpers for the JSON string unescape block.
package jsu_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CODE_W  = 16;
    localparam int unsigned ST_W    = 3;
    localparam int unsigned MAX_RES = 3;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_DONE     = 3'd1;
    localparam logic [ST_W-1:0] ST_NO_QUOTE = 3'd2;
    localparam logic [ST_W-1:0] ST_BAD_ESC  = 3'd3;
    localparam logic [ST_W-1:0] ST_BAD_HEX  = 3'd4;
    localparam logic [ST_W-1:0] ST_END_ESC  = 3'd5;
    localparam logic [ST_W-1:0] ST_UNTERM   = 3'd6;

    // Characters of interest
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_B     = 8'h62;
    localparam logic [BYTE_W-1:0] CH_F     = 8'h66;
    localparam logic [BYTE_W-1:0] CH_N     = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_R     = 8'h72;
    localparam logic [BYTE_W-1:0] CH_T     = 8'h74;
    localparam logic [BYTE_W-1:0] CH_U     = 8'h75;

    // Decoder mode, one-hot
    typedef enum logic [6:0] {
        MD_WAIT = 7'b0000001,
        MD_BODY = 7'b0000010,
        MD_ESC  = 7'b0000100,
        MD_HEX1 = 7'b0001000,
        MD_HEX2 = 7'b0010000,
        MD_HEX3 = 7'b0100000,
        MD_HEX4 = 7'b1000000
    } t_mode;

    // Results caused by one input item
    typedef struct packed {
        logic [1:0]                      cnt;
        logic [MAX_RES-1:0][BYTE_W-1:0]  bytes;
        logic                            bvalid;
        logic [ST_W-1:0]                 st;
    } t_bundle;

    typedef struct packed {
        t_mode               mode;
        logic [CODE_W-1:0]   accum;
        t_bundle             bundle;
    } t_dec;

    // {bad, value} of one hex digit
    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b0, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b0, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== src/jsu_decode.sv =====
`timescale 1ns / 1ps
// Combinational decoder: next mode, hex accumulator and result bundle for one byte.
module jsu_decode (
    input  jsu_pkg::t_mode                   i_mode,
    input  logic [jsu_pkg::CODE_W-1:0]       i_accum,
    input  logic [jsu_pkg::BYTE_W-1:0]       i_byte,
    input  logic                             i_end,
    output jsu_pkg::t_dec                    o_dec
);
    import jsu_pkg::*;

    logic [4:0]        hx;
    logic [CODE_W-1:0] code;
    logic [8:0]        esc;

    function automatic t_bundle status_res(input logic [ST_W-1:0] s);
        t_bundle b;
        b     = '0;
        b.cnt = 2'd1;
        b.st  = s;
        return b;
    endfunction

    function automatic t_bundle byte_res(input logic [BYTE_W-1:0] v);
        t_bundle b;
        b          = '0;
        b.cnt      = 2'd1;
        b.bvalid   = 1'b1;
        b.bytes[0] = v;
        return b;
    endfunction

    function automatic t_bundle utf8_res(input logic [CODE_W-1:0] cd);
        t_bundle b;
        b        = '0;
        b.bvalid = 1'b1;
        b.st     = ST_OK;
        if (cd <= 16'h007F) begin
            b.cnt      = 2'd1;
            b.bytes[0] = cd[7:0];
        end else if (cd <= 16'h07FF) begin
            b.cnt      = 2'd2;
            b.bytes[0] = 8'hC0 | {3'b000, cd[10:6]};
            b.bytes[1] = 8'h80 | {2'b00, cd[5:0]};
        end else begin
            b.cnt      = 2'd3;
            b.bytes[0] = 8'hE0 | {4'h0, cd[15:12]};
            b.bytes[1] = 8'h80 | {2'b00, cd[11:6]};
            b.bytes[2] = 8'h80 | {2'b00, cd[5:0]};
        end
        return b;
    endfunction

    assign hx   = hex_digit(i_byte);
    assign code = {i_accum[CODE_W-5:0], hx[3:0]};

    // Simple escape map: {miss, byte}
    always_comb begin
        case (i_byte)
            CH_QUOTE: esc = {1'b0, CH_QUOTE};
            CH_BSL:   esc = {1'b0, CH_BSL};
            CH_SLASH: esc = {1'b0, CH_SLASH};
            CH_B:     esc = {1'b0, 8'h08};
            CH_F:     esc = {1'b0, 8'h0C};
            CH_N:     esc = {1'b0, 8'h0A};
            CH_R:     esc = {1'b0, 8'h0D};
            CH_T:     esc = {1'b0, 8'h09};
            default:  esc = 9'h100;
        endcase
    end

    always_comb begin
        o_dec        = '0;
        o_dec.mode   = i_mode;
        o_dec.accum  = i_accum;
        if (i_end) begin
            if (i_mode == MD_BODY) begin
                o_dec.bundle = status_res(ST_UNTERM);
            end else if (i_mode != MD_WAIT) begin
                o_dec.bundle = status_res(ST_END_ESC);
            end
            o_dec.mode = MD_WAIT;
        end else begin
            case (i_mode)
                MD_BODY: begin
                    if (i_byte == CH_QUOTE) begin
                        o_dec.bundle = status_res(ST_DONE);
                        o_dec.mode   = MD_WAIT;
                    end else if (i_byte == CH_BSL) begin
                        o_dec.mode   = MD_ESC;
                    end else begin
                        o_dec.bundle = byte_res(i_byte);
                    end
                end
                MD_ESC: begin
                    if (!esc[8]) begin
                        o_dec.bundle = byte_res(esc[7:0]);
                        o_dec.mode   = MD_BODY;
                    end else if (i_byte == CH_U) begin
                        o_dec.accum  = '0;
                        o_dec.mode   = MD_HEX1;
                    end else begin
                        o_dec.bundle = status_res(ST_BAD_ESC);
                        o_dec.mode   = MD_WAIT;
                    end
                end
                MD_HEX1, MD_HEX2, MD_HEX3, MD_HEX4: begin
                    if (hx[4]) begin
                        o_dec.bundle = status_res(ST_BAD_HEX);
                        o_dec.mode   = MD_WAIT;
                    end else begin
                        o_dec.accum = code;
                        case (i_mode)
                            MD_HEX1: o_dec.mode = MD_HEX2;
                            MD_HEX2: o_dec.mode = MD_HEX3;
                            MD_HEX3: o_dec.mode = MD_HEX4;
                            default: begin
                                o_dec.bundle = utf8_res(code);
                                o_dec.mode   = MD_BODY;
                            end
                        endcase
                    end
                end
                default: begin
                    // waiting for the opening quote
                    if (i_byte == CH_QUOTE) begin
                        o_dec.mode   = MD_BODY;
                    end else begin
                        o_dec.bundle = status_res(ST_NO_QUOTE);
                        o_dec.mode   = MD_WAIT;
                    end
                end
            endcase
        end
    end

endmodule

// ===== src/json_string_unescape_core.sv =====
`timescale 1ns / 1ps
// Top level of the JSON string unescape block: decoder, result register and skid slot.
//
// Takes one text byte per transfer and decodes a quoted JSON string: raw bytes pass through,
// the eight simple escapes map to their bytes and \uXXXX becomes one to three UTF-8 bytes
// (surrogates are not paired). Every status (string done, no opening quote, bad escape,
// bad hex, end inside escape, unterminated) comes out as a result with byte_valid low,
// and o_last marks the final result of each input transfer. The decoder works on the input
// port combinationally and writes a result register, so one input transfer is taken per cycle
// unless stalled; an item of n output bytes holds the result register until all n are out.
// A second result slot (skid) lets the next input be taken while a result still waits, and
// o_in_ready drops only while that slot is full. There is no clearing pass after reset.
module json_string_unescape_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [jsu_pkg::BYTE_W-1:0]    i_byte_in,
    input  logic                          i_text_end,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [jsu_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                          o_byte_valid,
    output logic [jsu_pkg::ST_W-1:0]      o_status,
    output logic                          o_last
);
    import jsu_pkg::*;

    // Decoder state
    t_mode             r_mode;
    logic [CODE_W-1:0] r_accum;
    t_dec              dec;

    // Result register (slot A) and skid slot (slot B)
    t_bundle    r_a, n_a;
    logic       r_a_valid, n_a_valid;
    logic [1:0] r_a_pos, n_a_pos;
    t_bundle    r_b, n_b;
    logic       r_b_full, n_b_full;

    logic in_xfer;
    logic new_res;
    logic a_last;
    logic a_free;

    jsu_decode u_decode (
        .i_mode  (r_mode),
        .i_accum (r_accum),
        .i_byte  (i_byte_in),
        .i_end   (i_text_end),
        .o_dec   (dec)
    );

    assign o_in_ready = !r_b_full;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign new_res    = in_xfer && (dec.bundle.cnt != 2'd0);

    // Slot A is free when empty or when its last result is transferred this cycle
    assign a_last = (r_a_pos == (r_a.cnt - 2'd1));
    assign a_free = !r_a_valid || (i_out_ready && a_last);

    always_comb begin
        n_a       = r_a;
        n_a_valid = r_a_valid;
        n_a_pos   = r_a_pos;
        n_b       = r_b;
        n_b_full  = r_b_full;
        if (r_a_valid && i_out_ready && !a_last) begin
            n_a_pos = r_a_pos + 2'd1;
        end
        if (a_free) begin
            // refill from the skid slot first, else straight from the decoder
            n_a_pos = 2'd0;
            if (r_b_full) begin
                n_a       = r_b;
                n_a_valid = 1'b1;
                n_b_full  = 1'b0;
            end else if (new_res) begin
                n_a       = dec.bundle;
                n_a_valid = 1'b1;
            end else begin
                n_a_valid = 1'b0;
            end
        end else if (new_res) begin
            // hold the new results in the skid slot
            n_b      = dec.bundle;
            n_b_full = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MD_WAIT;
            r_accum   <= '0;
            r_a_valid <= 1'b0;
            r_a_pos   <= 2'd0;
            r_b_full  <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_mode  <= dec.mode;
                r_accum <= dec.accum;
            end
            r_a_valid <= n_a_valid;
            r_a_pos   <= n_a_pos;
            r_b_full  <= n_b_full;
        end
    end

    // Payload slots carry no reset
    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
    end

    assign o_out_valid  = r_a_valid;
    assign o_out_byte   = r_a.bytes[r_a_pos];
    assign o_byte_valid = r_a.bvalid;
    assign o_status     = r_a.st;
    assign o_last       = a_last;

    // The skid slot only fills behind a busy result register
    a_skid_behind_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_full |-> r_a_valid)
        else $error("skid slot full while result register empty");

    // A status result is always the only, and so the last, result of its transfer
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_last && !o_byte_valid))
        else $error("status result not last or flagged as byte");

    // End of text always returns the decoder to waiting for a quote
    a_end_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_text_end) |=> (r_mode == MD_WAIT))
        else $error("decoder not waiting after end of text");

    // The read position never runs past the results held
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (r_a_pos < r_a.cnt))
        else $error("result position beyond bundle");

endmodule

// ===== sim/tb_json_string_unescape_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the JSON string unescape core.
module tb_json_string_unescape_core;
    import jsu_pkg::*;

    // Give up after this many cycles with no transfer on either channel
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    // Receiver hold-off used to fill the block and stall its input
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned RANDOM_ITEMS   = 250;
    localparam int unsigned PRESSURE_ITEMS = 40;
    localparam int unsigned REPORT_MAX     = 10;

    // One decoded result as the block should present it
    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              ch_ok;
        logic [ST_W-1:0]   st;
        logic              fin;
    } t_decoded;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [BYTE_W-1:0]  i_byte_in   = '0;
    logic               i_text_end  = 1'b0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [BYTE_W-1:0]  o_out_byte;
    logic               o_byte_valid;
    logic [ST_W-1:0]    o_status;
    logic               o_last;

    // Decoder state mirrored by the predictor
    t_mode             dec_mode = MD_WAIT;
    logic [CODE_W-1:0] dec_code = '0;

    // Results still owed by the block, oldest first
    t_decoded          decoded_q[$];

    int unsigned       mismatches   = 0;
    int unsigned       live_items   = 0;
    int unsigned       idle_cycles  = 0;
    int unsigned       hold_request = 0;
    // While set, neither side inserts random gaps
    bit                calm         = 1'b0;

    json_string_unescape_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_byte_in    (i_byte_in),
        .i_text_end   (i_text_end),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    always #1 i_clk = ~i_clk;

    // Mostly back-to-back, sometimes a short pause, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic t_decoded byte_rec(input logic [BYTE_W-1:0] b);
        t_decoded r;
        r = '{ch: b, ch_ok: 1'b1, st: ST_OK, fin: 1'b0};
        return r;
    endfunction

    function automatic t_decoded status_rec(input logic [ST_W-1:0] s);
        t_decoded r;
        r = '{ch: '0, ch_ok: 1'b0, st: s, fin: 1'b0};
        return r;
    endfunction

    // Hex digit character for a nibble, letters in either case
    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return 8'h30 + v;
        end
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + (v - 4'd10);
    endfunction

    // Work out what one accepted transfer must produce and advance the mirrored state.
    task automatic predict_transfer(input logic [BYTE_W-1:0] b, input logic e);
        t_decoded          res[$];
        int                hv;
        logic [CODE_W-1:0] cp;
        hv = -1;
        if (e) begin
            // Text end: only meaningful once a string has been opened
            if (dec_mode == MD_BODY) begin
                res = {res, status_rec(ST_UNTERM)};
            end else if (dec_mode != MD_WAIT) begin
                res = {res, status_rec(ST_END_ESC)};
            end
            dec_mode = MD_WAIT;
        end else begin
            case (dec_mode)
                MD_WAIT: begin
                    if (b == CH_QUOTE) begin
                        dec_mode = MD_BODY;
                    end else begin
                        res = {res, status_rec(ST_NO_QUOTE)};
                    end
                end
                MD_BODY: begin
                    if (b == CH_QUOTE) begin
                        res = {res, status_rec(ST_DONE)};
                        dec_mode = MD_WAIT;
                    end else if (b == CH_BSL) begin
                        dec_mode = MD_ESC;
                    end else begin
                        res = {res, byte_rec(b)};
                    end
                end
                MD_ESC: begin
                    dec_mode = MD_BODY;
                    case (b)
                        CH_QUOTE, CH_BSL, CH_SLASH: res = {res, byte_rec(b)};
                        CH_B: res = {res, byte_rec(8'h08)};
                        CH_F: res = {res, byte_rec(8'h0C)};
                        CH_N: res = {res, byte_rec(8'h0A)};
                        CH_R: res = {res, byte_rec(8'h0D)};
                        CH_T: res = {res, byte_rec(8'h09)};
                        CH_U: begin
                            dec_code = '0;
                            dec_mode = MD_HEX1;
                        end
                        default: begin
                            res = {res, status_rec(ST_BAD_ESC)};
                            dec_mode = MD_WAIT;
                        end
                    endcase
                end
                default: begin
                    // One of the four hex digit positions
                    if (b inside {[8'h30:8'h39]}) begin
                        hv = b - 8'h30;
                    end else if (b inside {[8'h41:8'h46]}) begin
                        hv = b - 8'h37;
                    end else if (b inside {[8'h61:8'h66]}) begin
                        hv = b - 8'h57;
                    end
                    if (hv < 0) begin
                        res = {res, status_rec(ST_BAD_HEX)};
                        dec_mode = MD_WAIT;
                    end else begin
                        cp       = {dec_code[11:0], hv[3:0]};
                        dec_code = cp;
                        case (dec_mode)
                            MD_HEX1: dec_mode = MD_HEX2;
                            MD_HEX2: dec_mode = MD_HEX3;
                            MD_HEX3: dec_mode = MD_HEX4;
                            default: begin
                                // Fourth digit: encode the code point as UTF-8
                                dec_mode = MD_BODY;
                                if (cp <= 16'h007F) begin
                                    res = {res, byte_rec(cp[7:0])};
                                end else if (cp <= 16'h07FF) begin
                                    res = {res, byte_rec({3'b110, cp[10:6]})};
                                    res = {res, byte_rec({2'b10, cp[5:0]})};
                                end else begin
                                    res = {res, byte_rec({4'b1110, cp[15:12]})};
                                    res = {res, byte_rec({2'b10, cp[11:6]})};
                                    res = {res, byte_rec({2'b10, cp[5:0]})};
                                end
                            end
                        endcase
                    end
                end
            endcase
        end
        if (res.size() > 0) begin
            res[res.size() - 1].fin = 1'b1;
        end
        decoded_q = {decoded_q, res};
    endtask

    // Offer one text item and hold it until the block takes it.
    // Valid is only lowered when a gap follows, so it never toggles within one step.
    task automatic send_text(input logic [BYTE_W-1:0] b, input logic e);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_in  <= b;
        i_text_end <= e;
        do @(posedge i_clk); while (!o_in_ready);
        // Text end outside a string changes nothing: leave it out of the count
        if (!(e && dec_mode == MD_WAIT)) begin
            live_items++;
        end
        predict_transfer(b, e);
    endtask

    task automatic send_end();
        send_text(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_escape(input logic [BYTE_W-1:0] letter);
        send_text(CH_BSL, 1'b0);
        send_text(letter, 1'b0);
    endtask

    task automatic send_unicode(input logic [CODE_W-1:0] cp);
        send_escape(CH_U);
        send_text(hex_char(cp[15:12]), 1'b0);
        send_text(hex_char(cp[11:8]), 1'b0);
        send_text(hex_char(cp[7:4]), 1'b0);
        send_text(hex_char(cp[3:0]), 1'b0);
    endtask

    // Drop valid and wait until every owed result has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_escape();
        case ($urandom_range(0, 7))
            0:       return CH_QUOTE;
            1:       return CH_BSL;
            2:       return CH_SLASH;
            3:       return CH_B;
            4:       return CH_F;
            5:       return CH_N;
            6:       return CH_R;
            default: return CH_T;
        endcase
    endfunction

    // Byte that is not a hex digit, often one just beside a digit range
    function automatic logic [BYTE_W-1:0] pick_bad_hex();
        logic [BYTE_W-1:0] b;
        case ($urandom_range(0, 6))
            0:       b = 8'h2F;
            1:       b = 8'h3A;
            2:       b = 8'h40;
            3:       b = 8'h47;
            4:       b = 8'h60;
            5:       b = 8'h67;
            default: begin
                do b = 8'($urandom_range(0, 255));
                while (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
            end
        endcase
        return b;
    endfunction

    // One quoted token with random content; most are well formed, some broken
    task automatic send_token();
        int unsigned       n_elem;
        int unsigned       good;
        logic [BYTE_W-1:0] b;
        logic [CODE_W-1:0] cp;
        // Occasional noise outside a string
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_end();
                end else begin
                    send_text(8'($urandom_range(0, 255)), 1'b0);
                end
            end
        end
        send_text(CH_QUOTE, 1'b0);
        n_elem = $urandom_range(0, 6);
        repeat (n_elem) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    do b = 8'($urandom_range(0, 255));
                    while (b == CH_QUOTE || b == CH_BSL);
                    send_text(b, 1'b0);
                end
                4, 5, 6: send_escape(pick_escape());
                default: begin
                    // Spread code points over the one, two and three byte forms
                    case ($urandom_range(0, 2))
                        0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
                        1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                        default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                    endcase
                    send_unicode(cp);
                end
            endcase
        end
        case ($urandom_range(0, 9))
            7: send_end();
            8: begin
                send_text(CH_BSL, 1'b0);
                if ($urandom_range(0, 1)) begin
                    send_end();
                end else begin
                    do b = 8'($urandom_range(0, 255));
                    while (b inside {CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F,
                                     CH_N, CH_R, CH_T, CH_U});
                    send_text(b, 1'b0);
                end
            end
            9: begin
                send_escape(CH_U);
                good = $urandom_range(0, 3);
                repeat (good) send_text(hex_char(4'($urandom_range(0, 15))), 1'b0);
                if ($urandom_range(0, 2) == 0) begin
                    send_end();
                end else begin
                    send_text(pick_bad_hex(), 1'b0);
                end
            end
            default: send_text(CH_QUOTE, 1'b0);
        endcase
        if ($urandom_range(0, 5) == 0) begin
            send_end();
        end
    endtask

    // Bytes outside a string: text end is ignored, anything but a quote is refused
    task automatic test_outside_string();
        send_end();
        send_text(8'hFF, 1'b0);
        send_text(8'h00, 1'b0);
        send_text(CH_BSL, 1'b0);
        wait_drained();
    endtask

    // Raw bytes at both extremes and all eight simple escapes
    task automatic test_simple_escapes();
        send_text(CH_QUOTE, 1'b0);
        send_text(8'h00, 1'b0);
        send_text(8'hFF, 1'b0);
        send_escape(CH_QUOTE);
        send_escape(CH_BSL);
        send_escape(CH_SLASH);
        send_escape(CH_B);
        send_escape(CH_F);
        send_escape(CH_N);
        send_escape(CH_R);
        send_escape(CH_T);
        send_text(CH_QUOTE, 1'b0);
        wait_drained();
    endtask

    // Code points on the edges of the one, two and three byte UTF-8 forms
    task automatic test_unicode();
        send_text(CH_QUOTE, 1'b0);
        send_unicode(16'h007F);
        send_unicode(16'h0080);
        send_unicode(16'h07FF);
        send_unicode(16'hFFFF);
        send_text(CH_QUOTE, 1'b0);
        wait_drained();
    endtask

    // Bad escape, bad hex, end inside an escape and an unterminated string, each opened by a fresh quote
    task automatic test_errors();
        send_text(CH_QUOTE, 1'b0);
        send_escape("x");
        send_text(CH_QUOTE, 1'b0);
        send_escape(CH_U);
        send_text("1", 1'b0);
        send_text("g", 1'b0);
        send_text(CH_QUOTE, 1'b0);
        send_text(CH_BSL, 1'b0);
        send_end();
        send_text(CH_QUOTE, 1'b0);
        send_escape(CH_U);
        send_text("A", 1'b0);
        send_end();
        send_text(CH_QUOTE, 1'b0);
        send_text("a", 1'b0);
        send_end();
        wait_drained();
    endtask

    // Random tokens with calm stretches mixed in
    task automatic test_random_tokens();
        int unsigned start;
        start = live_items;
        while (live_items - start < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 7) == 0);
            send_token();
        end
        calm = 1'b0;
        wait_drained();
    endtask

    // Hold the receiver off while items keep coming, so the block fills and stalls
    task automatic test_backpressure();
        int unsigned start;
        start        = live_items;
        calm         = 1'b1;
        hold_request = HOLD_CYCLES;
        while (live_items - start < PRESSURE_ITEMS) begin
            send_token();
        end
        calm = 1'b0;
        wait_drained();
    endtask

    // Receiver side: random stalls, or a long counted hold-off when one is requested
    initial begin : out_ready_drive
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (!calm) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Compare each result transfer with the oldest owed result
    always @(posedge i_clk) begin : check_results
        t_decoded want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (decoded_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected result: byte %02h valid %0b status %0d last %0b",
                             o_out_byte, o_byte_valid, o_status, o_last);
                end
            end else begin
                want = decoded_q.pop_front();
                if (o_out_byte !== want.ch || o_byte_valid !== want.ch_ok ||
                    o_status !== want.st || o_last !== want.fin) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("mismatch: expected byte %02h valid %0b status %0d last %0b",
                                 want.ch, want.ch_ok, want.st, want.fin);
                        $display("          actual   byte %02h valid %0b status %0d last %0b",
                                 o_out_byte, o_byte_valid, o_status, o_last);
                    end
                end
            end
        end
    end

    // Watchdog: a run that stops moving is a failure
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_outside_string();
        test_simple_escapes();
        test_unicode();
        test_errors();
        test_random_tokens();
        test_backpressure();
        // Give any stray result time to show up before judging
        repeat (16) @(posedge i_clk);
        mismatches += decoded_q.size();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
